>>> design/flc_pkg.sv
// Shared types, constants and bit-search functions for the fault list cursor.
`default_nettype none

package flc_pkg;

    localparam int NUM_SUBSYS = 32;
    localparam int FUNC_BITS  = 32;
    localparam int SUB_W      = 5;
    localparam int FN_W       = 6;
    localparam int CQ_DEPTH   = 2;
    localparam int CQ_AW      = 1;
    localparam int CQ_CW      = 2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_PREV  = 2'd1;
    localparam logic [1:0] OP_NEXT  = 2'd2;

    typedef logic [FUNC_BITS-1:0]  t_fmask;
    typedef logic [NUM_SUBSYS-1:0] t_svec;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  subsystem_sel;
        logic [31:0] fault_mask;
    } t_in_item;

    typedef struct packed {
        logic [4:0] cur_subsystem;
        logic [5:0] cur_function;
        logic       any_fault;
    } t_out_item;

    typedef enum logic [1:0] {
        K_WRITE,
        K_PREV,
        K_NEXT,
        K_REPORT
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [SUB_W-1:0]  sub;
        t_fmask            mask;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_LAND,
        S_REPORT
    } t_bstate;

    // 1-based index of the lowest set bit
    function automatic logic [FN_W-1:0] f_bit_low(input t_fmask m);
        logic [FN_W-1:0] idx;
        idx = '0;
        for (int i = FUNC_BITS - 1; i >= 0; i--) begin
            if (m[i]) idx = FN_W'(i + 1);
        end
        return idx;
    endfunction

    // 1-based index of the highest set bit
    function automatic logic [FN_W-1:0] f_bit_high(input t_fmask m);
        logic [FN_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < FUNC_BITS; i++) begin
            if (m[i]) idx = FN_W'(i + 1);
        end
        return idx;
    endfunction

    function automatic logic [SUB_W-1:0] f_sub_low(input t_svec v);
        logic [SUB_W-1:0] idx;
        idx = '0;
        for (int i = NUM_SUBSYS - 1; i >= 0; i--) begin
            if (v[i]) idx = SUB_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [SUB_W-1:0] f_sub_high(input t_svec v);
        logic [SUB_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < NUM_SUBSYS; i++) begin
            if (v[i]) idx = SUB_W'(i);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> design/flc_front.sv
// Front end: accepts input transactions, classifies them and queues commands.
`default_nettype none

module flc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire flc_pkg::t_in_item i_item,
    output logic                   o_cmd_valid,
    output flc_pkg::t_cmd          o_cmd,
    input  wire logic              i_cmd_pop
);
    import flc_pkg::*;

    t_cmd             r_q [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wp;
    logic [CQ_AW-1:0] r_rp;
    logic [CQ_CW-1:0] r_cnt;
    logic [CQ_CW-1:0] n_cnt;
    t_cmd             cls;
    logic             acc;

    always_comb begin
        cls.sub  = i_item.subsystem_sel;
        cls.mask = t_fmask'(i_item.fault_mask);
        case (i_item.operation)
            OP_WRITE: cls.kind = (32'(i_item.subsystem_sel) < NUM_SUBSYS) ? K_WRITE : K_REPORT;
            OP_PREV:  cls.kind = K_PREV;
            OP_NEXT:  cls.kind = K_NEXT;
            default:  cls.kind = K_REPORT;
        endcase
    end

    assign full        = (r_cnt == CQ_CW'(CQ_DEPTH));
    assign acc         = push && !full;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (acc && !(i_cmd_pop && o_cmd_valid)) n_cnt = r_cnt + 1'b1;
        else if (!acc && i_cmd_pop && o_cmd_valid) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (acc) r_wp <= r_wp + 1'b1;
            if (i_cmd_pop && o_cmd_valid) r_rp <= r_rp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_q[r_wp] <= cls;
    end

endmodule

`default_nettype wire

>>> design/flc_back.sv
// Back end: fault table, cursor sequencer and result register.
`default_nettype none

module flc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire flc_pkg::t_cmd      i_cmd,
    output logic                    o_cmd_pop,
    output logic                    empty,
    input  wire logic               pop,
    output flc_pkg::t_out_item      o_item
);
    import flc_pkg::*;

    t_fmask           r_table [NUM_SUBSYS];
    t_svec            r_nz;
    t_fmask           r_rdata;
    t_kind            r_kind;
    t_bstate          r_state;
    t_bstate          n_state;
    logic [SUB_W-1:0] r_cur_sub;
    logic [SUB_W-1:0] n_cur_sub;
    logic [FN_W-1:0]  r_cur_fn;
    logic [FN_W-1:0]  n_cur_fn;
    t_out_item        r_out;
    logic             r_out_vld;

    logic             rd_en;
    logic [SUB_W-1:0] rd_addr;
    logic             tbl_we;
    logic             load_out;
    t_fmask           lo_m;
    t_fmask           hi_m;
    t_svec            sub_lo;
    t_svec            sub_hi;
    t_fmask           prev_hits;
    t_fmask           next_hits;
    logic [SUB_W-1:0] prev_sub;
    logic [SUB_W-1:0] next_sub;
    logic             any;

    assign any = |r_nz;

    always_comb begin
        for (int i = 0; i < FUNC_BITS; i++) begin
            lo_m[i] = (FN_W'(i + 1) < r_cur_fn);
            hi_m[i] = (FN_W'(i) >= r_cur_fn);
        end
        for (int j = 0; j < NUM_SUBSYS; j++) begin
            sub_lo[j] = (SUB_W'(j) < r_cur_sub);
            sub_hi[j] = (SUB_W'(j) > r_cur_sub);
        end
        prev_hits = r_rdata & lo_m;
        next_hits = r_rdata & hi_m;
        prev_sub  = (|(r_nz & sub_lo)) ? f_sub_high(r_nz & sub_lo) : f_sub_high(r_nz);
        next_sub  = (|(r_nz & sub_hi)) ? f_sub_low(r_nz & sub_hi) : f_sub_low(r_nz);
    end

    always_comb begin
        n_state   = r_state;
        n_cur_sub = r_cur_sub;
        n_cur_fn  = r_cur_fn;
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_cur_sub;
        tbl_we    = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !r_out_vld) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        K_WRITE: begin
                            tbl_we  = 1'b1;
                            n_state = S_REPORT;
                        end
                        K_PREV, K_NEXT: begin
                            rd_en   = 1'b1;
                            n_state = S_LOOK;
                        end
                        default: n_state = S_REPORT;
                    endcase
                end
            end
            S_LOOK: begin
                if (!any) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_kind == K_PREV && |prev_hits) begin
                    n_cur_fn = f_bit_high(prev_hits);
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_kind == K_NEXT && |next_hits) begin
                    n_cur_fn = f_bit_low(next_hits);
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_cur_sub = (r_kind == K_PREV) ? prev_sub : next_sub;
                    rd_en     = 1'b1;
                    rd_addr   = n_cur_sub;
                    n_state   = S_LAND;
                end
            end
            S_LAND: begin
                n_cur_fn = (r_kind == K_PREV) ? f_bit_high(r_rdata) : f_bit_low(r_rdata);
                load_out = 1'b1;
                n_state  = S_IDLE;
            end
            S_REPORT: begin
                load_out = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur_sub <= '0;
            r_cur_fn  <= '0;
            r_nz      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur_sub <= n_cur_sub;
            r_cur_fn  <= n_cur_fn;
            if (tbl_we) r_nz[i_cmd.sub] <= |i_cmd.mask;
            if (load_out) r_out_vld <= 1'b1;
            else if (pop) r_out_vld <= 1'b0;
        end
    end

    // table entries with a clear nonzero flag read as zero
    always_ff @(posedge i_clk) begin
        if (tbl_we) r_table[i_cmd.sub] <= i_cmd.mask;
        if (rd_en) r_rdata <= r_nz[rd_addr] ? r_table[rd_addr] : '0;
        if (o_cmd_pop) r_kind <= i_cmd.kind;
        if (load_out) begin
            r_out.cur_subsystem <= n_cur_sub;
            r_out.cur_function  <= n_cur_fn;
            r_out.any_fault     <= any;
        end
    end

    assign empty  = !r_out_vld;
    assign o_item = r_out;

endmodule

`default_nettype wire

>>> design/fault_list_cursor.sv
// Top level of the fault list cursor: command front end and table back end.
//
//  channel   handshake         payload
//  input     push / full       i_item (operation, subsystem_sel, fault_mask)
//  result    empty / pop       o_item (cur_subsystem, cur_function, any_fault)
//
// The back end takes a command from the two-entry queue in the cycle after
// acceptance at the earliest. With no wait, writes and unused codes finish in
// the report state; moves with no fault set or within the current subsystem
// finish in the look state, and a search across subsystems in the land state
// after a second table read. A command starts only when the result register
// is free. Reset clears the queue, the cursor and the nonzero flags.
`default_nettype none

module fault_list_cursor (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire flc_pkg::t_in_item   i_item,
    output logic                     empty,
    input  wire logic                pop,
    output flc_pkg::t_out_item       o_item
);
    import flc_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    flc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    flc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item)
    );

endmodule

`default_nettype wire
